// ----- src/gda_pkg.sv -----
// Shared types, constants and small helper functions for the Gregorian date advance block.
// No dependencies; gregorian_date_advance and its checker import this package.
package gda_pkg;

  // Field widths of the input and result items.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned YOE_W   = 9;

  // Result packing: year, month, day, weekday, padded to whole bytes.
  localparam int unsigned OUT_FIELDS_W = YEAR_W + MONTH_W + DAY_W + WD_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Calendar constants.
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 14'd1754;
  localparam logic [MONTH_W-1:0] MONTHS_IN_YR  = 4'd12;
  localparam logic [YOE_W-1:0]   ERA_YEARS     = 9'd400;
  localparam logic [YOE_W-1:0]   LAST_YOE      = 9'd399;
  localparam logic [YOE_W-1:0]   YEAR_LEN      = 9'd365;
  localparam logic [YOE_W-1:0]   LEAP_YEAR_LEN = 9'd366;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN  = 5'd29;
  localparam logic [DAY_W-1:0]   MIN_MONTH_LEN = 5'd28;
  localparam logic [WD_W-1:0]    WEEK_DAYS     = 3'd7;
  // Every year that is a multiple of 400 starts on a Saturday (Monday is 0).
  localparam logic [WD_W-1:0]    ERA_WEEKDAY   = 3'd5;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Leap rule on the year within its 400-year era.
  function automatic logic is_leap_yoe(input logic [YOE_W-1:0] yoe);
    logic century;
    century = (yoe == 9'd100) || (yoe == 9'd200) || (yoe == 9'd300);
    return (yoe[1:0] == 2'b00) && !century;
  endfunction

  // Length of a month; months outside 1..12 give the January length.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    if (m == 4'd0 || m > MONTHS_IN_YR) begin
      return MONTH_DAYS[0];
    end
    if (m == 4'd2 && leap) begin
      return FEB_LEAP_LEN;
    end
    return MONTH_DAYS[idx];
  endfunction

  // Weekday plus a small step, modulo 7; both arguments are below 7.
  function automatic logic [WD_W-1:0] wd_add(input logic [WD_W-1:0] wd,
                                             input logic [WD_W-1:0] inc);
    logic [WD_W:0] s;
    s = {1'b0, wd} + {1'b0, inc};
    if (s >= {1'b0, WEEK_DAYS}) begin
      s = s - {1'b0, WEEK_DAYS};
    end
    return s[WD_W-1:0];
  endfunction

endpackage

// ----- src/gda_step_unit.sv -----
// Shared add/subtract-and-compare unit used by the date sequencer for its add and subtract steps.
// Depends on nothing but its width parameter.
module gda_step_unit #(
  parameter int unsigned W = 22
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         carry_o
);

  logic [W:0] sum;
  logic [W:0] b_ext;

  // For a subtraction the carry out means a_i >= b_i.
  assign b_ext   = sub_i ? {1'b0, ~b_i} : {1'b0, b_i};
  assign sum     = {1'b0, a_i} + b_ext + {{W{1'b0}}, sub_i};
  assign res_o   = sum[W-1:0];
  assign carry_o = sum[W];

endmodule

// ----- src/gregorian_date_advance.sv -----
// Gregorian date advance: validates a date and walks it forward by a day count.
// The shared step unit takes one step a cycle.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops a pending result.
// Depends on gda_pkg and gda_step_unit.
module gregorian_date_advance #(
  parameter int unsigned DAYS_WIDTH = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  // year [13:0], month [17:14], day [22:18], days_to_advance [DAYS_WIDTH+22:23], zero pad
  input  logic [((23 + DAYS_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // out_year [13:0], out_month [17:14], out_day [22:18], weekday [25:23], zero pad
  output logic [gda_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // bad_date [0]
  output logic m_axis_tuser_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i
);
  import gda_pkg::*;

  localparam int unsigned IN_POS_N = YEAR_W + MONTH_W + DAY_W;
  // Running day offset: day count plus up to a year's worth of days.
  localparam int unsigned TW = (DAYS_WIDTH + 2 > YEAR_W) ? DAYS_WIDTH + 2 : YEAR_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD400,
    ST_WEEK,
    ST_CHECK,
    ST_MONACC,
    ST_YEAR,
    ST_MONTH,
    ST_DAYMOD,
    ST_FIN
  } state_e;

  state_e                 state_q;
  logic [TW-1:0]          t_q;
  logic [DAYS_WIDTH-1:0]  n_q;
  logic [YEAR_W-1:0]      year_q;
  logic [MONTH_W-1:0]     mon_q;
  logic [DAY_W-1:0]       day_q;
  logic [YOE_W-1:0]       yoe_q;
  logic [YOE_W-1:0]       idx_q;
  logic [WD_W-1:0]        wd_q;
  logic                   bad_q;
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   out_bad_q;

  logic [YEAR_W-1:0]      in_year;
  logic [MONTH_W-1:0]     in_month;
  logic [DAY_W-1:0]       in_day;
  logic [DAYS_WIDTH-1:0]  in_days;

  logic                   leap_cur;
  logic                   leap_idx;
  logic [MONTH_W-1:0]     mlen_month;
  logic [DAY_W-1:0]       mlen;
  logic [YOE_W-1:0]       ylen;
  logic [TW-1:0]          op_b;
  logic                   op_sub;
  logic [TW-1:0]          step_res;
  logic                   step_ge;
  logic                   slot_free;

  // Unpack the request.
  assign in_year  = s_axis_tdata_i[YEAR_W-1:0];
  assign in_month = s_axis_tdata_i[YEAR_W+MONTH_W-1:YEAR_W];
  assign in_day   = s_axis_tdata_i[IN_POS_N-1:YEAR_W+MONTH_W];
  assign in_days  = s_axis_tdata_i[IN_POS_N+DAYS_WIDTH-1:IN_POS_N];

  // Calendar lookups for the current step.
  assign leap_cur   = is_leap_yoe(yoe_q);
  assign leap_idx   = is_leap_yoe(idx_q);
  assign mlen_month = (state_q == ST_MONACC) ? idx_q[MONTH_W-1:0] : mon_q;
  assign mlen       = month_len(mlen_month, leap_cur);
  assign ylen       = leap_cur ? LEAP_YEAR_LEN : YEAR_LEN;

  // Operand select for the shared step unit.
  always_comb begin
    op_sub = 1'b1;
    case (state_q)
      ST_MOD400: op_b = TW'(ERA_YEARS);
      ST_MONACC: begin
        op_b   = TW'(mlen);
        op_sub = 1'b0;
      end
      ST_YEAR:   op_b = TW'(ylen);
      ST_MONTH:  op_b = TW'(mlen);
      ST_DAYMOD: op_b = TW'(WEEK_DAYS);
      default:   op_b = '0;
    endcase
  end

  gda_step_unit #(.W(TW)) u_step (
    .a_i     (t_q),
    .b_i     (op_b),
    .sub_i   (op_sub),
    .res_o   (step_res),
    .carry_o (step_ge)
  );

  assign slot_free = !out_valid_q || m_axis_tready_i;

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      n_q         <= '0;
      year_q      <= '0;
      mon_q       <= '0;
      day_q       <= '0;
      yoe_q       <= '0;
      idx_q       <= '0;
      wd_q        <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // Take a request and screen the year and month ranges.
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            year_q <= in_year;
            mon_q  <= in_month;
            day_q  <= in_day;
            n_q    <= in_days;
            t_q    <= TW'(in_year);
            if (in_year < EPOCH_YEAR || in_month == '0 || in_month > MONTHS_IN_YR) begin
              bad_q   <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              bad_q   <= 1'b0;
              state_q <= ST_MOD400;
            end
          end
        end
        // Reduce the year to its place within the 400-year era.
        ST_MOD400: begin
          if (step_ge) begin
            t_q <= step_res;
          end else begin
            yoe_q   <= t_q[YOE_W-1:0];
            idx_q   <= '0;
            wd_q    <= ERA_WEEKDAY;
            state_q <= ST_WEEK;
          end
        end
        // Walk from the era start to find the weekday of 1 January.
        ST_WEEK: begin
          if (idx_q == yoe_q) begin
            state_q <= ST_CHECK;
          end else begin
            wd_q  <= wd_add(wd_q, leap_idx ? 3'd2 : 3'd1);
            idx_q <= idx_q + 9'd1;
          end
        end
        // Check the day against the month length, then seed the offset.
        ST_CHECK: begin
          if (day_q == '0 || day_q > mlen) begin
            bad_q   <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            t_q     <= TW'(n_q) + TW'(day_q - 5'd1);
            idx_q   <= 9'd1;
            state_q <= ST_MONACC;
          end
        end
        // Add the lengths of the months before the starting month.
        ST_MONACC: begin
          if (idx_q[MONTH_W-1:0] == mon_q) begin
            mon_q   <= 4'd1;
            state_q <= ST_YEAR;
          end else begin
            t_q   <= step_res;
            idx_q <= idx_q + 9'd1;
          end
        end
        // Skip whole years while the offset covers the current one.
        ST_YEAR: begin
          if (step_ge) begin
            t_q    <= step_res;
            year_q <= year_q + 14'd1;
            yoe_q  <= (yoe_q == LAST_YOE) ? '0 : yoe_q + 9'd1;
            wd_q   <= wd_add(wd_q, leap_cur ? 3'd2 : 3'd1);
          end else begin
            state_q <= ST_MONTH;
          end
        end
        // Skip whole months of the final year.
        ST_MONTH: begin
          if (step_ge) begin
            t_q   <= step_res;
            mon_q <= mon_q + 4'd1;
            wd_q  <= wd_add(wd_q, WD_W'(mlen - MIN_MONTH_LEN));
          end else begin
            day_q   <= t_q[DAY_W-1:0] + 5'd1;
            state_q <= ST_DAYMOD;
          end
        end
        // Fold the day within the month into the weekday.
        ST_DAYMOD: begin
          if (step_ge) begin
            t_q <= step_res;
          end else begin
            wd_q    <= wd_add(wd_q, t_q[WD_W-1:0]);
            state_q <= ST_FIN;
          end
        end
        // Hand the result to the output register once it is free.
        ST_FIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_bad_q   <= bad_q;
            if (bad_q) begin
              out_data_q <= '0;
            end else begin
              out_data_q <= OUT_DATA_W'({wd_q, day_q, mon_q, year_q});
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_bad_q;

endmodule

// ----- src/gregorian_date_advance_chk.sv -----
// Port-level checker for the Gregorian date advance block, bound to its top level.
// Depends on gda_pkg for the result field layout.
module gregorian_date_advance_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [gda_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i
);
  import gda_pkg::*;

  logic [MONTH_W-1:0] mon;
  logic [DAY_W-1:0]   day;
  logic [WD_W-1:0]    wd;

  assign mon = m_axis_tdata_o[YEAR_W+MONTH_W-1:YEAR_W];
  assign day = m_axis_tdata_o[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];
  assign wd  = m_axis_tdata_o[OUT_FIELDS_W-1:YEAR_W+MONTH_W+DAY_W];

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result request withdrawn while stalled");

  // A stalled result keeps its contents.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A rejected date carries an all-zero date.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("rejected date has nonzero fields");

  // An accepted date comes out as a real calendar date.
  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      mon != '0 && mon <= MONTHS_IN_YR && day != '0 && wd < WEEK_DAYS)
    else $error("advanced date out of range");

endmodule

bind gregorian_date_advance gregorian_date_advance_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
